### hw/rtl/bmpg_pkg.sv
// Shared types and constants for the BMP stream to gray frame writer.
// Used by the front parser, the item queue, the back stage and the top level.
// No dependencies.
package bmpg_pkg;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    localparam logic [1:0]  STATUS_OK        = 2'd0;
    localparam logic [1:0]  STATUS_BAD_DEPTH = 2'd1;
    localparam logic [1:0]  STATUS_BAD_SIG   = 2'd2;

    localparam logic [7:0]  SIG_BYTE0 = 8'h42;
    localparam logic [7:0]  SIG_BYTE1 = 8'h4d;

    localparam logic [10:0] OFF_SIG0      = 11'h000;
    localparam logic [10:0] OFF_SIG1      = 11'h001;
    localparam logic [10:0] OFF_WIDTH_LO  = 11'h012;
    localparam logic [10:0] OFF_WIDTH_HI  = 11'h013;
    localparam logic [10:0] OFF_HEIGHT_LO = 11'h016;
    localparam logic [10:0] OFF_HEIGHT_HI = 11'h017;
    localparam logic [10:0] OFF_DEPTH     = 11'h01c;
    localparam logic [10:0] OFF_HDR_LAST  = 11'h035;
    localparam logic [10:0] OFF_DATA8     = 11'h436;
    localparam logic [10:0] OFF_MAX       = 11'h7ff;

    localparam logic [7:0]  DEPTH_24 = 8'd24;
    localparam logic [7:0]  DEPTH_8  = 8'd8;

    // floor(x / 3) == (x * 683) >> 11 for x < 2048
    localparam logic [20:0] DIV3_MUL   = 21'd683;
    localparam int          DIV3_SHIFT = 11;

    localparam int TDATA_W = 80;

    typedef struct packed {
        logic        pixel;
        logic [7:0]  value;
        logic [15:0] flipped;
        logic [15:0] column;
        logic [15:0] width;
        logic [15:0] height;
        logic        done;
        logic [1:0]  status;
    } qent_t;

endpackage

### hw/rtl/bmpg_front.sv
// Front parser: header capture, signature and depth check, pixel grouping.
// Emits one queue entry per pixel write or per header verdict that ends the file.
// Depends on bmpg_pkg.
module bmpg_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     data_byte,
    input  logic           file_start,
    output logic           push,
    output bmpg_pkg::qent_t entry
);
    import bmpg_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [10:0] off_reg, off_next;
    logic [1:0]  sig_reg, sig_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [9:0]  tsum_reg, tsum_next;
    logic [1:0]  tcnt_reg, tcnt_next;

    phase_t      ph_b;
    logic [10:0] cur;
    logic [1:0]  sig_b;
    logic [15:0] w_b, h_b, col_b, row_b;
    logic [7:0]  d_b;
    logic [9:0]  ts_b;
    logic [1:0]  tc_b;

    logic        hdr_end, hdr_finish, depth_ok, is24;
    logic [1:0]  hdr_status;
    logic        pix_byte, pix_emit, last_pix;
    logic [9:0]  tsum_add;
    logic [20:0] div_prod;
    logic [7:0]  pix_value;

    always_comb
    begin
        if (file_start)
        begin
            ph_b  = PH_HEADER;
            cur   = '0;
            sig_b = '0;
            w_b   = '0;
            h_b   = '0;
            d_b   = '0;
            col_b = '0;
            row_b = '0;
            ts_b  = '0;
            tc_b  = '0;
        end
        else
        begin
            ph_b  = phase_reg;
            cur   = off_reg;
            sig_b = sig_reg;
            w_b   = width_reg;
            h_b   = height_reg;
            d_b   = depth_reg;
            col_b = col_reg;
            row_b = row_reg;
            ts_b  = tsum_reg;
            tc_b  = tcnt_reg;
        end
    end

    assign is24     = (d_b == DEPTH_24);
    assign depth_ok = is24 || (d_b == DEPTH_8);
    assign hdr_end  = take && (ph_b == PH_HEADER) && (cur == OFF_HDR_LAST);

    always_comb
    begin
        if (sig_b != 2'b11)
            hdr_status = STATUS_BAD_SIG;
        else if (!depth_ok)
            hdr_status = STATUS_BAD_DEPTH;
        else
            hdr_status = STATUS_OK;
    end

    assign hdr_finish = hdr_end &&
        ((sig_b != 2'b11) || !depth_ok || (w_b == 16'd0) || (h_b == 16'd0));

    assign pix_byte = take && ((ph_b == PH_PIXELS) ||
                               ((ph_b == PH_SKIP) && (cur >= OFF_DATA8)));
    assign pix_emit = pix_byte && (!is24 || (tc_b == 2'd2));
    assign last_pix = (row_b == h_b - 16'd1) && (col_b == w_b - 16'd1);

    assign tsum_add  = ts_b + {2'b00, data_byte};
    assign div_prod  = {11'b0, tsum_add} * DIV3_MUL;
    assign pix_value = is24 ? div_prod[DIV3_SHIFT +: 8] : data_byte;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = ph_b;
            case (ph_b)
                PH_HEADER:
                begin
                    if (hdr_end)
                    begin
                        if (hdr_finish)
                            phase_next = PH_DONE;
                        else
                            phase_next = is24 ? PH_PIXELS : PH_SKIP;
                    end
                end
                PH_SKIP, PH_PIXELS:
                begin
                    if (pix_emit && last_pix)
                        phase_next = PH_DONE;
                    else if (pix_byte)
                        phase_next = PH_PIXELS;
                end
                PH_DONE:    phase_next = PH_DONE;
                default:    phase_next = PH_DONE;
            endcase
        end
    end

    // datapath and queue entry
    always_comb
    begin
        off_next    = off_reg;
        sig_next    = sig_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        tsum_next   = tsum_reg;
        tcnt_next   = tcnt_reg;

        if (take)
        begin
            off_next    = (cur == OFF_MAX) ? cur : cur + 11'd1;
            sig_next    = sig_b;
            width_next  = w_b;
            height_next = h_b;
            depth_next  = d_b;
            col_next    = col_b;
            row_next    = row_b;
            tsum_next   = ts_b;
            tcnt_next   = tc_b;

            if (ph_b == PH_HEADER)
            begin
                if (cur == OFF_SIG0 && data_byte == SIG_BYTE0)
                    sig_next[0] = 1'b1;
                if (cur == OFF_SIG1 && data_byte == SIG_BYTE1)
                    sig_next[1] = 1'b1;
                if (cur == OFF_WIDTH_LO)
                    width_next[7:0] = data_byte;
                if (cur == OFF_WIDTH_HI)
                    width_next[15:8] = data_byte;
                if (cur == OFF_HEIGHT_LO)
                    height_next[7:0] = data_byte;
                if (cur == OFF_HEIGHT_HI)
                    height_next[15:8] = data_byte;
                if (cur == OFF_DEPTH)
                    depth_next = data_byte;
            end

            if (pix_byte && is24)
            begin
                if (tc_b == 2'd2)
                begin
                    tsum_next = '0;
                    tcnt_next = '0;
                end
                else
                begin
                    tsum_next = tsum_add;
                    tcnt_next = tc_b + 2'd1;
                end
            end

            if (pix_emit)
            begin
                if ({1'b0, col_b} + 17'd1 >= {1'b0, w_b})
                begin
                    col_next = '0;
                    row_next = row_b + 16'd1;
                end
                else
                begin
                    col_next = col_b + 16'd1;
                end
            end
        end

        push          = pix_emit || hdr_finish;
        entry.pixel   = pix_emit;
        entry.value   = pix_value;
        entry.flipped = h_b - 16'd1 - row_b;
        entry.column  = col_b;
        entry.width   = w_b;
        entry.height  = h_b;
        entry.done    = pix_emit ? last_pix : 1'b1;
        entry.status  = pix_emit ? STATUS_OK : hdr_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            off_reg    <= '0;
            sig_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            tsum_reg   <= '0;
            tcnt_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            sig_reg    <= sig_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            tsum_reg   <= tsum_next;
            tcnt_reg   <= tcnt_next;
        end
    end

endmodule

### hw/rtl/bmpg_fifo.sv
// Short queue of parsed entries between the front parser and the back stage.
// Register array with combinational read of the head entry.
// Depends on bmpg_pkg.
module bmpg_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bmpg_pkg::qent_t wr_entry,
    input  logic            pop,
    output bmpg_pkg::qent_t rd_entry,
    output logic            full,
    output logic            empty
);
    import bmpg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qent_t          mem [DEPTH];
    logic [PW-1:0]  wptr_reg, wptr_next;
    logic [PW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign rd_entry = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        if (pop)
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### hw/rtl/bmpg_back.sv
// Back stage: frame address computation and output register.
// Pops one queue entry whenever the queue holds one and the output register is free or being taken.
// Depends on bmpg_pkg.
module bmpg_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bmpg_pkg::qent_t                 entry,
    input  logic                            empty,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmpg_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import bmpg_pkg::*;

    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg;
    logic               last_reg;
    logic               user_reg;
    logic [31:0]        prod;
    logic [31:0]        addr;
    logic [7:0]         value;

    assign pop        = !empty && (!valid_reg || m_tready);
    assign prod       = {16'b0, entry.flipped} * {16'b0, entry.width};
    assign addr       = entry.pixel ? prod + {16'b0, entry.column} : 32'd0;
    assign value      = entry.pixel ? entry.value : 8'd0;
    assign valid_next = pop || (valid_reg && !m_tready);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= {6'b0, entry.height, entry.width, entry.status, value, addr};
            last_reg <= entry.done;
            user_reg <= entry.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

### hw/rtl/bmp_stream_to_gray_frame.sv
// Top level of the BMP byte stream to gray frame-buffer writer.
// Instantiates bmpg_front, bmpg_fifo and bmpg_back; depends on bmpg_pkg.
//
//   channel  | dir | tdata (low bit up)                         | tuser       | tlast
//   s_ (in)  | in  | data_byte[7:0]                             | file_start  | -
//   m_ (out) | out | pixel_address[31:0] pixel_value[39:32]     | pixel_valid | done_res
//            |     | status[41:40] image_width[57:42]           |             |
//            |     | image_height[73:58] zero[79:74]            |             |
//
// One input item per cycle while the queue is not full; the parser decodes each byte as it is taken.
// A result passes through the queue and then the back stage, where one
// 16x16 multiply and add form the address before the output register.
// Reset empties the queue and the output register and returns to the header.
// s_tready drops only while the queue is full; m_ stalls fill the queue.
module bmp_stream_to_gray_frame #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // data_byte
    input  logic                            s_tuser,  // file_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmpg_pkg::TDATA_W-1:0]    m_tdata,  // address, value, status, width, height
    output logic                            m_tlast,  // done_res
    output logic                            m_tuser   // pixel_valid
);
    import bmpg_pkg::*;

    logic   take;
    logic   front_push;
    qent_t  front_entry;
    qent_t  head_entry;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    bmpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (s_tdata),
        .file_start (s_tuser),
        .push       (front_push),
        .entry      (front_entry)
    );

    bmpg_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .wr_entry (front_entry),
        .pop      (q_pop),
        .rd_entry (head_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    bmpg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .entry    (head_entry),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        front_push |-> !q_full)
        else $error("queue push while full");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_nonpixel_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("result without pixel is not the final one");

    a_pixel_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[41:40] == STATUS_OK))
        else $error("pixel write with error status");
`endif

endmodule

### bench/tb_bmp_stream_to_gray_frame.sv
// Self-checking bench for bmp_stream_to_gray_frame: feeds BMP byte streams and
// checks every frame write and header verdict against an in-bench decoder.
// Depends on bmpg_pkg and the bmp_stream_to_gray_frame RTL.
`timescale 1ns / 100ps

module tb_bmp_stream_to_gray_frame;

    import bmpg_pkg::*;

    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          ITEM_TARGET = 1850;
    localparam int          RANDOM_WRITES = 16;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_HOLD  = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    typedef struct packed {
        logic        pixel;
        logic [31:0] address;
        logic [7:0]  value;
        logic        done;
        logic [1:0]  status;
        logic [15:0] width;
        logic [15:0] height;
    } frame_write_t;

    typedef struct packed {
        logic [7:0]  sig0;
        logic [7:0]  sig1;
        logic [7:0]  depth;
        logic [15:0] width;
        logic [15:0] height;
        int          cut;
        bit          lead;
        int          fill;
        int          trailer;
        bit          typed;
        logic [1:0]  status;
        logic [1:0]  mode;
    } bmp_case_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    bmp_stream_to_gray_frame u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // decoder state
    logic [10:0] off_q;
    phase_t      ph;
    logic [1:0]  sig_seen;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  depth;
    logic [15:0] col;
    logic [15:0] rw;
    logic [9:0]  tri_sum;
    logic [1:0]  tri_cnt;

    frame_write_t pending_writes[$];
    bmp_case_t    dir_cases [12];

    bit          hold_req = 1'b0;
    bit          steady_feed = 1'b0;
    int          holds_done = 0;
    int          fail_count = 0;
    int          writes_expected = 0;
    int          writes_checked = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int unsigned cycle_count = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_parser();
        off_q = '0;
        ph = PH_HEADER;
        sig_seen = '0;
        img_w = '0;
        img_h = '0;
        depth = '0;
        col = '0;
        rw = '0;
        tri_sum = '0;
        tri_cnt = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic st,
                               output bit has, output frame_write_t r);
        logic [10:0] cur;
        logic [15:0] flipped;
        logic [31:0] px_addr;
        logic [7:0]  value;
        logic [1:0]  verdict;
        bit          judged;
        bit          take;
        bit          emit;
        bit          last;
        has = 1'b0;
        r = '0;
        judged = 1'b0;
        take = 1'b0;
        emit = 1'b0;
        last = 1'b0;
        value = '0;
        verdict = STATUS_OK;
        if (st)
            clear_parser();
        cur = off_q;
        if (off_q < OFF_MAX)
            off_q = off_q + 11'd1;
        case (ph)
            PH_HEADER:
            begin
                if (cur == OFF_SIG0 && b == SIG_BYTE0) sig_seen[0] = 1'b1;
                if (cur == OFF_SIG1 && b == SIG_BYTE1) sig_seen[1] = 1'b1;
                if (cur == OFF_WIDTH_LO) img_w[7:0] = b;
                if (cur == OFF_WIDTH_HI) img_w[15:8] = b;
                if (cur == OFF_HEIGHT_LO) img_h[7:0] = b;
                if (cur == OFF_HEIGHT_HI) img_h[15:8] = b;
                if (cur == OFF_DEPTH) depth = b;
                if (cur == OFF_HDR_LAST)
                begin
                    judged = 1'b1;
                    if (sig_seen != 2'b11)
                        verdict = STATUS_BAD_SIG;
                    else if (depth != DEPTH_24 && depth != DEPTH_8)
                        verdict = STATUS_BAD_DEPTH;
                    else if (img_w == 16'd0 || img_h == 16'd0)
                        verdict = STATUS_OK;
                    else
                    begin
                        judged = 1'b0;
                        if (depth == DEPTH_24)
                            ph = PH_PIXELS;
                        else
                            ph = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (cur >= OFF_DATA8)
                begin
                    ph = PH_PIXELS;
                    take = 1'b1;
                end
            end
            PH_PIXELS:
                take = 1'b1;
            default:
                ;
        endcase
        if (take)
        begin
            if (depth == DEPTH_24)
            begin
                tri_sum = tri_sum + 10'(b);
                tri_cnt = tri_cnt + 2'd1;
                if (tri_cnt == 2'd3)
                begin
                    value = 8'(tri_sum / 10'd3);
                    tri_sum = '0;
                    tri_cnt = '0;
                    emit = 1'b1;
                end
            end
            else
            begin
                value = b;
                emit = 1'b1;
            end
        end
        if (judged)
        begin
            ph = PH_DONE;
            has = 1'b1;
            r = '{pixel: 1'b0, address: '0, value: '0, done: 1'b1, status: verdict,
                  width: img_w, height: img_h};
        end
        if (emit)
        begin
            flipped = img_h - 16'd1 - rw;
            last = (rw == img_h - 16'd1) && (col == img_w - 16'd1);
            px_addr = 32'(flipped) * 32'(img_w) + 32'(col);
            if (32'(col) + 32'd1 >= 32'(img_w))
            begin
                col = '0;
                rw = rw + 16'd1;
            end
            else
                col = col + 16'd1;
            if (last)
                ph = PH_DONE;
            has = 1'b1;
            r = '{pixel: 1'b1, address: px_addr, value: value, done: last,
                  status: STATUS_OK, width: img_w, height: img_h};
        end
    endtask

    // Offer one item, wait for the handshake, then record what it should produce.
    task automatic send_item(input logic [7:0] b, input logic st, input bit use_typed,
                             input frame_write_t typed_res);
        int          gap_n;
        bit          has;
        frame_write_t r;
        gap_n = steady_feed ? 0 : pick_gap();
        if (gap_n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= st;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        decode_byte(b, st, has, r);
        if (use_typed)
        begin
            pending_writes.push_back(typed_res);
            writes_expected++;
        end
        else if (has)
        begin
            pending_writes.push_back(r);
            writes_expected++;
        end
    endtask

    task automatic send_file(input bmp_case_t c);
        logic [7:0]   hdr [0:53];
        longint       data_start;
        longint       total;
        longint       send_len;
        longint       i;
        bit           good;
        logic [7:0]   b;
        frame_write_t verdict;
        if (c.mode == MODE_DRAIN)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending_writes.size() != 0) @(posedge clk);
        end
        if (c.mode == MODE_HOLD)
            hold_req = 1'b1;
        steady_feed = (c.mode == MODE_HOLD) || ($urandom_range(0, 6) == 0);
        for (int j = 0; j < 54; j++)
            hdr[j] = 8'($urandom);
        hdr[OFF_SIG0] = c.sig0;
        hdr[OFF_SIG1] = c.sig1;
        hdr[OFF_WIDTH_LO] = c.width[7:0];
        hdr[OFF_WIDTH_HI] = c.width[15:8];
        hdr[OFF_HEIGHT_LO] = c.height[7:0];
        hdr[OFF_HEIGHT_HI] = c.height[15:8];
        hdr[OFF_DEPTH] = c.depth;
        good = c.sig0 == SIG_BYTE0 && c.sig1 == SIG_BYTE1 &&
               (c.depth == DEPTH_24 || c.depth == DEPTH_8) &&
               c.width != 16'd0 && c.height != 16'd0;
        data_start = (c.depth == DEPTH_8) ? longint'(OFF_DATA8)
                                          : longint'(OFF_HDR_LAST) + 1;
        total = 54;
        if (good)
            total = data_start + longint'(c.width) * longint'(c.height) *
                    ((c.depth == DEPTH_24) ? 3 : 1);
        send_len = (c.cut >= 0 && c.cut < total) ? longint'(c.cut) : total;
        verdict = '{pixel: 1'b0, address: '0, value: '0, done: 1'b1, status: c.status,
                    width: c.width, height: c.height};
        for (i = 0; i < send_len; i++)
        begin
            if (i < 54)
                b = hdr[i];
            else if (good && c.fill >= 0 && i >= data_start)
                b = 8'(c.fill);
            else
                b = 8'($urandom);
            send_item(b, c.lead && (i == 0),
                      c.typed && (i == longint'(OFF_HDR_LAST)), verdict);
        end
        if (send_len == total)
            repeat (c.trailer) send_item(8'($urandom), 1'b0, 1'b0, verdict);
        files_sent++;
    endtask

    // Receiver side: random stalls, plus long hold-offs on request.
    initial
    begin : ready_driver
        int gap_n;
        int run_n;
        int k;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                gap_n = pick_gap();
                if (gap_n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap_n) @(posedge clk);
                end
                m_tready <= 1'b1;
                run_n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
                k = 0;
                do
                begin
                    @(posedge clk);
                    k++;
                end
                while (k < run_n && !hold_req);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        frame_write_t got;
        frame_write_t want;
        bit           bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{pixel: m_tuser, address: m_tdata[31:0], value: m_tdata[39:32],
                    done: m_tlast, status: m_tdata[41:40], width: m_tdata[57:42],
                    height: m_tdata[73:58]};
            if (pending_writes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: v=%0d a=%h val=%h d=%0d st=%0d",
                             got.pixel, got.address, got.value, got.done, got.status);
            end
            else
            begin
                want = pending_writes.pop_front();
                writes_checked++;
                bad = (got.pixel !== want.pixel) || (got.address !== want.address) ||
                      (got.value !== want.value) || (got.done !== want.done) ||
                      (got.status !== want.status) || (got.width !== want.width) ||
                      (got.height !== want.height);
                if (bad)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("#%0d expected: v=%0d a=%h val=%h d=%0d st=%0d w=%h h=%h",
                                 writes_checked, want.pixel, want.address, want.value,
                                 want.done, want.status, want.width, want.height);
                        $display("#%0d actual:   v=%0d a=%h val=%h d=%0d st=%0d w=%h h=%h",
                                 writes_checked, got.pixel, got.address, got.value,
                                 got.done, got.status, got.width, got.height);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_writes.size());
            $display("bmp_stream_to_gray_frame: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        bmp_case_t c;
        int        base_writes;
        int        pick;
        int        r2;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        clear_parser();

        // sig0, sig1, depth, width, height, cut, lead, fill, trailer, typed, status, mode
        dir_cases = '{
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'd2, 16'd2, -1, 1'b0, -1, 5, 1'b0,
              STATUS_OK, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'd1, 16'd1, -1, 1'b1, 255, 3, 1'b0,
              STATUS_OK, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'd3, 16'd2, 61, 1'b1, -1, 0, 1'b0,
              STATUS_OK, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'd4, 16'd3, -1, 1'b1, -1, 2, 1'b0,
              STATUS_OK, MODE_HOLD},
            '{SIG_BYTE0, 8'h00, DEPTH_24, 16'd5, 16'd5, -1, 1'b1, -1, 4, 1'b1,
              STATUS_BAD_SIG, MODE_DRAIN},
            '{8'hff, 8'hff, 8'd7, 16'hffff, 16'hffff, -1, 1'b1, -1, 1, 1'b1,
              STATUS_BAD_SIG, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, 8'd16, 16'd4, 16'd4, -1, 1'b1, -1, 0, 1'b1,
              STATUS_BAD_DEPTH, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'd0, 16'd7, -1, 1'b1, -1, 0, 1'b1,
              STATUS_OK, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_8, 16'd9, 16'd0, -1, 1'b1, -1, 0, 1'b1,
              STATUS_OK, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'hffff, 16'hffff, 84, 1'b1, -1, 0, 1'b0,
              STATUS_OK, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'd2, 16'd3, 20, 1'b1, -1, 0, 1'b0,
              STATUS_OK, MODE_PLAIN},
            '{SIG_BYTE0, SIG_BYTE1, DEPTH_8, 16'd3, 16'd2, -1, 1'b1, -1, 4, 1'b0,
              STATUS_OK, MODE_DRAIN}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_cases[i])
            send_file(dir_cases[i]);

        base_writes = writes_expected;
        while (bytes_sent < ITEM_TARGET ||
               writes_expected - base_writes < RANDOM_WRITES)
        begin
            c = '{SIG_BYTE0, SIG_BYTE1, DEPTH_24, 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 6)), -1, 1'b1, -1, $urandom_range(0, 3), 1'b0,
                  STATUS_OK, MODE_PLAIN};
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                c.width = 16'($urandom_range(1, 65535));
                c.height = 16'($urandom_range(1, 65535));
                c.cut = 54 + $urandom_range(0, 60);
            end
            else if (pick < 11)
            begin
                c.depth = DEPTH_8;
                c.width = 16'($urandom_range(1, 6));
                c.height = 16'($urandom_range(1, 5));
                c.cut = 54 + $urandom_range(0, 60);
            end
            else if (pick < 19)
            begin
                c.sig0 = 8'($urandom);
                c.sig1 = 8'($urandom);
                if (c.sig0 == SIG_BYTE0 && c.sig1 == SIG_BYTE1)
                    c.sig1 = c.sig1 ^ (8'd1 << $urandom_range(0, 7));
                c.depth = ($urandom_range(0, 1) == 0) ? DEPTH_24 : 8'($urandom);
                c.width = 16'($urandom);
                c.height = 16'($urandom);
            end
            else if (pick < 25)
            begin
                do
                    c.depth = 8'($urandom);
                while (c.depth == DEPTH_24 || c.depth == DEPTH_8);
                c.width = 16'($urandom);
                c.height = 16'($urandom);
            end
            else if (pick < 29)
            begin
                c.depth = ($urandom_range(0, 1) == 0) ? DEPTH_24 : DEPTH_8;
                if ($urandom_range(0, 1) == 0)
                begin
                    c.width = '0;
                    c.height = 16'($urandom);
                end
                else
                begin
                    c.width = 16'($urandom);
                    c.height = '0;
                end
            end
            else if (pick < 37)
                c.cut = $urandom_range(1, 53 + 3 * int'(c.width) * int'(c.height));
            if ($urandom_range(0, 49) == 0)
                c.lead = 1'b0;
            r2 = $urandom_range(0, 99);
            if (r2 < 2)
                c.mode = MODE_HOLD;
            else if (r2 < 6)
                c.mode = MODE_DRAIN;
            send_file(c);
        end

        // drain: let every outstanding result come out, then let the clock run idle
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("fed %0d files (%0d directed) as %0d bytes; %0d results checked",
                 files_sent, $size(dir_cases), bytes_sent, writes_checked);
        $display("header errors, zero sizes, restarts, %0d receiver hold-offs",
                 holds_done);
        if (fail_count == 0 && pending_writes.size() == 0)
            $display("bmp_stream_to_gray_frame: match");
        else
            $display("bmp_stream_to_gray_frame: mismatch");
        $finish;
    end

endmodule
